// File: hdl/mtg_pkg.sv
// Package for the MT19937 generator: word type, generator constants and
// the status struct passed from the fill unit to the top level.
// No dependencies.
`default_nettype none

package mtg_pkg;

  typedef logic [31:0] word_t;

  // Table geometry defaults
  localparam int MtgTableDepth  = 624;
  localparam int MtgTwistOffset = 397;

  // Twist, initialization and tempering constants
  localparam word_t TwistMatrix = 32'h9908_b0df;
  localparam word_t HighBit     = 32'h8000_0000;
  localparam word_t LowBits     = 32'h7fff_ffff;
  localparam word_t InitMult    = 32'd1812433253;
  localparam word_t TemperB     = 32'h9d2c_5680;
  localparam word_t TemperC     = 32'hefc6_0000;
  localparam word_t DefaultSeed = 32'd5489;
  localparam word_t SeedLimit   = 32'd9999;

  // Input operation codes
  localparam logic OpSeed = 1'b0;
  localparam logic OpNext = 1'b1;

  // Fill unit status
  typedef struct packed {
    logic step;  // shift the chain this cycle
    logic done;  // this step writes the last table word
  } fill_status_t;

endpackage : mtg_pkg

`default_nettype wire

// File: hdl/mersenne_twister_generator.sv
// MT19937 generator top level: chain of word cells, fill unit, twist and
// tempering logic, control and output register.
// Depends on mtg_pkg, mtg_cell and mtg_fill.
`default_nettype none

// The 624-word state lives in a row of cells that shifts toward the head;
// the head cell is always the next word to be twisted. A next transaction
// twists the head word from cells 0, 1 and 397, shifts the twisted word in
// at the tail and returns its tempered value, so next transactions can be
// taken on consecutive cycles while the output side keeps up. A seed
// transaction saturates its value to 9999 and shifts the initialization
// sequence into the chain, one word per cycle through the fill unit's
// multiplier: the input stays stalled until the last table word is
// written, and nothing is returned. A next transaction that arrives
// before any seed first runs that fill with seed 5489, then returns its
// word once the output register is free, the input staying stalled until
// that word is in the output register.
// Twisting word by word in chain order gives the same sequence as
// regenerating the whole table every 624 words.
module mersenne_twister_generator
  import mtg_pkg::*;
#(
  parameter int TABLE_DEPTH  = MtgTableDepth,
  parameter int TWIST_OFFSET = MtgTwistOffset
) (
  input  wire   clk,
  input  wire   rst,
  // Input channel
  input  wire   in_valid,
  output logic  in_stall,
  input  wire   operation,
  input  word_t seed_value,
  // Output channel
  output logic  out_valid,
  input  wire   out_stall,
  output word_t random_word
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_WORD
  } state_t;

  state_t       state;
  logic         seeded;
  logic         word_pending;

  logic         accept;
  logic         out_free;
  logic         fill_start;
  logic         twist_en;
  logic         shift;
  word_t        fill_seed;
  word_t        fill_word;
  fill_status_t fill_status;
  word_t        tail_in;
  word_t        twist_word;
  word_t        chain [TABLE_DEPTH];

  function automatic word_t temper(input word_t x);
    word_t y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  // Start a fill on a seed transaction or on a next transaction before any seed
  assign fill_start = accept && ((operation == OpSeed) || !seeded);
  always_comb begin
    if (operation == OpNext) begin
      fill_seed = DefaultSeed;
    end else if (seed_value > SeedLimit) begin
      fill_seed = SeedLimit;
    end else begin
      fill_seed = seed_value;
    end
  end

  mtg_fill #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_fill (
    .clk      (clk),
    .rst      (rst),
    .start    (fill_start),
    .seed     (fill_seed),
    .tail_word(chain[TABLE_DEPTH-1]),
    .fill_word(fill_word),
    .status   (fill_status)
  );

  // Twist the head word
  always_comb begin
    word_t y;
    y          = (chain[0] & HighBit) | (chain[1] & LowBits);
    twist_word = chain[TWIST_OFFSET] ^ (y >> 1);
    if (y[0]) begin
      twist_word = twist_word ^ TwistMatrix;
    end
  end

  assign twist_en = (accept && (operation == OpNext) && seeded)
                  || ((state == S_WORD) && out_free);
  assign shift    = fill_status.step || twist_en;
  assign tail_in  = fill_status.step ? fill_word : twist_word;

  // Chain of cells shifting toward the head
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_tail
      mtg_cell u_cell (
        .clk  (clk),
        .shift(shift),
        .din  (tail_in),
        .dout (chain[i])
      );
    end else begin : g_body
      mtg_cell u_cell (
        .clk  (clk),
        .shift(shift),
        .din  (chain[i+1]),
        .dout (chain[i])
      );
    end
  end

  // Control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      seeded       <= 1'b0;
      word_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (twist_en) begin
        out_valid   <= 1'b1;
        random_word <= temper(twist_word);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (fill_start) begin
            state        <= S_FILL;
            seeded       <= 1'b1;
            word_pending <= (operation == OpNext);
          end
        end
        S_FILL: begin
          if (fill_status.done) begin
            state <= word_pending ? S_WORD : S_IDLE;
          end
        end
        S_WORD: begin
          if (out_free) begin
            state        <= S_IDLE;
            word_pending <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : mersenne_twister_generator

`default_nettype wire

// File: hdl/mtg_cell.sv
// One cell of the state chain: holds a single 32-bit table word and takes
// the word of its right-hand neighbor on each shift.
// Depends on mtg_pkg.
`default_nettype none

module mtg_cell
  import mtg_pkg::*;
(
  input  wire   clk,
  input  wire   shift,
  input  word_t din,
  output word_t dout
);

  word_t word_q;

  // Take the neighbor's word on shift, hold otherwise
  always_ff @(posedge clk) begin
    if (shift) begin
      word_q <= din;
    end
  end

  assign dout = word_q;

endmodule : mtg_cell

`default_nettype wire

// File: hdl/mtg_fill.sv
// Seed fill unit: produces the Knuth-multiplier initialization sequence,
// one table word per cycle, for shifting into the tail of the cell chain.
// Depends on mtg_pkg.
`default_nettype none

module mtg_fill
  import mtg_pkg::*;
#(
  parameter int TABLE_DEPTH = MtgTableDepth
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          start,
  input  word_t        seed,
  input  word_t        tail_word,
  output word_t        fill_word,
  output fill_status_t status
);

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  logic            active;
  logic [IdxW-1:0] idx;
  word_t           mix;
  word_t           prod;

  // Recurrence: INIT_MULT * (prev ^ (prev >> 30)) + index
  assign mix  = tail_word ^ (tail_word >> 30);
  assign prod = InitMult * mix;

  always_comb begin
    if (start) begin
      fill_word = seed;
    end else begin
      fill_word = prod + {{(32 - IdxW){1'b0}}, idx};
    end
  end

  assign status.step = start | active;
  assign status.done = active && (idx == LastIdx);

  // Advance the index until the last table word is written
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (start) begin
      active <= 1'b1;
      idx    <= IdxW'(1);
    end else if (active) begin
      if (idx == LastIdx) begin
        active <= 1'b0;
      end
      idx <= idx + IdxW'(1);
    end
  end

endmodule : mtg_fill

`default_nettype wire
